/* rtl/ifa_pkg.sv */
// shared types, constants and register codes of the imu frame assembler
// no dependencies
package ifa_pkg;

  localparam int unsigned ID_W      = 29;
  localparam int unsigned PAY_W     = 64;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ADDR_W    = 5;
  localparam int unsigned DATA_W    = 32;
  localparam int unsigned IDX_W     = 6;
  localparam int unsigned SEQ_W     = 7;
  localparam int unsigned TICK_W    = 16;

  localparam int unsigned SEQ_WRAP_DEF = 127;

  localparam logic [31:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // packet byte positions
  localparam logic [IDX_W-1:0] IDX_FIRST     = 6'd0;
  localparam logic [IDX_W-1:0] IDX_REC_FIRST = 6'd4;
  localparam logic [IDX_W-1:0] IDX_REC_LAST  = 6'd31;
  localparam logic [IDX_W-1:0] IDX_LAST      = 6'd35;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_HEADER = 3'd0;
  localparam logic [2:0] REG_TEMP   = 3'd1;
  localparam logic [2:0] REG_STATUS = 3'd2;
  localparam logic [2:0] REG_ID_XY  = 3'd3;
  localparam logic [2:0] REG_ID_Z   = 3'd4;
  localparam logic [2:0] REG_PERIOD = 3'd5;

  localparam logic [31:0]       RST_HEADER = 32'h55FF_81FE;
  localparam logic [15:0]       RST_TEMP   = 16'd40;
  localparam logic [7:0]        RST_STATUS = 8'd119;
  localparam logic [ID_W-1:0]   RST_ID_XY  = 29'h102;
  localparam logic [ID_W-1:0]   RST_ID_Z   = 29'h103;
  localparam logic [TICK_W-1:0] RST_PERIOD = 16'd20;

  localparam logic CMD_FRAME = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  typedef struct packed {
    logic [31:0]        frame_header;
    logic signed [15:0] temperature;
    logic [7:0]         status_byte;
    logic [ID_W-1:0]    id_rate_xy;
    logic [ID_W-1:0]    id_rate_z;
    logic [TICK_W-1:0]  send_period;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CRC,
    ST_SEND
  } state_t;

endpackage

/* rtl/ifa_can_if.sv */
// input channel: can frames and millisecond ticks
// depends on ifa_pkg
interface ifa_can_if
  import ifa_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             cmd;
  logic [ID_W-1:0]  can_id;
  logic [PAY_W-1:0] can_payload;

  modport source (output valid, cmd, can_id, can_payload, input ready);
  modport sink   (input valid, cmd, can_id, can_payload, output ready);
endinterface

/* rtl/ifa_ser_if.sv */
// output channel: serial packet bytes
// depends on ifa_pkg
interface ifa_ser_if
  import ifa_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              frame_last;

  modport source (output valid, out_byte, frame_last, input ready);
  modport sink   (input valid, out_byte, frame_last, output ready);
endinterface

/* rtl/imu_frame_assembler_crc32.sv */
// imu frame assembler: can rotation frames in, crc-32 protected serial packet out
// a z frame starts a commit: the crc unit takes the record bytes one byte a cycle
// x/y frames and ticks are taken in idle; the input stays closed during a commit and a send,
// and a send tick starts a packet sent one byte a cycle unless the receiver stalls a byte
// the output register frees the input side once the last packet byte is loaded
// reset: rst synchronous active high, clears control and record state and loads register defaults
module imu_frame_assembler_crc32
  import ifa_pkg::*;
#(
  parameter int unsigned SEQ_WRAP = SEQ_WRAP_DEF
) (
  input  logic              clk,
  input  logic              rst,
  ifa_can_if.sink           can_ch,
  ifa_ser_if.source         ser_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  cfg_t cfg;

  state_t state;
  state_t state_next;

  // record state
  logic [31:0]       rot_x_bytes;
  logic [31:0]       rot_y_bytes;
  logic [31:0]       rot_z_bytes;
  logic [SEQ_W-1:0]  seq_count;
  logic              send_pending;
  logic [TICK_W-1:0] tick_count;
  logic [31:0]       crc_latched;

  // packet byte index, shared by the crc pass and the send pass
  logic [IDX_W-1:0]  idx;
  logic [BYTE_W-1:0] sel_byte;

  // output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  // control strobes
  logic              in_ready;
  logic              in_acc;
  logic              is_xy;
  logic              is_z;
  logic              is_tick;
  logic              period_hit;
  logic              crc_init;
  logic              crc_step;
  logic              out_load;
  logic              send_start;
  logic              send_done;

  logic [TICK_W:0]   tick_sum;
  logic [SEQ_W:0]    seq_sum;
  logic [SEQ_W-1:0]  seq_next;

  ifa_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // the crc register doubles as the latched crc; it only moves during a commit
  ifa_crc_unit u_crc (
    .clk  (clk),
    .rst  (rst),
    .init (crc_init),
    .step (crc_step),
    .data (sel_byte),
    .crc  (crc_latched)
  );

  // input decode; an x/y match wins when both ids are equal
  assign in_acc  = can_ch.valid && in_ready;
  assign is_tick = (can_ch.cmd == CMD_TICK);
  assign is_xy   = !is_tick && (can_ch.can_id == cfg.id_rate_xy);
  assign is_z    = !is_tick && !is_xy && (can_ch.can_id == cfg.id_rate_z);

  // tick counter compare, one bit wider so a lowered period still fires
  assign tick_sum   = {1'b0, tick_count} + 1'b1;
  assign period_hit = !(tick_sum < {1'b0, cfg.send_period});

  // sequence advance with wrap at SEQ_WRAP and at the field width
  assign seq_sum  = {1'b0, seq_count} + 1'b1;
  assign seq_next = (seq_sum == (SEQ_W+1)'(SEQ_WRAP)) ? '0 : seq_sum[SEQ_W-1:0];

  // packet byte selector: header, record, crc msb first
  always_comb begin
    case (idx)
      6'd0:    sel_byte = cfg.frame_header[7:0];
      6'd1:    sel_byte = cfg.frame_header[15:8];
      6'd2:    sel_byte = cfg.frame_header[23:16];
      6'd3:    sel_byte = cfg.frame_header[31:24];
      6'd4:    sel_byte = rot_x_bytes[7:0];
      6'd5:    sel_byte = rot_x_bytes[15:8];
      6'd6:    sel_byte = rot_x_bytes[23:16];
      6'd7:    sel_byte = rot_x_bytes[31:24];
      6'd8:    sel_byte = rot_y_bytes[7:0];
      6'd9:    sel_byte = rot_y_bytes[15:8];
      6'd10:   sel_byte = rot_y_bytes[23:16];
      6'd11:   sel_byte = rot_y_bytes[31:24];
      6'd12:   sel_byte = rot_z_bytes[7:0];
      6'd13:   sel_byte = rot_z_bytes[15:8];
      6'd14:   sel_byte = rot_z_bytes[23:16];
      6'd15:   sel_byte = rot_z_bytes[31:24];
      6'd28:   sel_byte = cfg.status_byte;
      6'd29:   sel_byte = {1'b0, seq_count};
      6'd30:   sel_byte = cfg.temperature[7:0];
      6'd31:   sel_byte = cfg.temperature[15:8];
      6'd32:   sel_byte = crc_latched[31:24];
      6'd33:   sel_byte = crc_latched[23:16];
      6'd34:   sel_byte = crc_latched[15:8];
      6'd35:   sel_byte = crc_latched[7:0];
      default: sel_byte = '0; // acceleration words and unused codes
    endcase
  end

  // sequencer: next state and strobes
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    crc_init   = 1'b0;
    crc_step   = 1'b0;
    out_load   = 1'b0;
    send_start = 1'b0;
    send_done  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // ready is high throughout idle, so valid alone marks a transaction
        in_ready = 1'b1;
        if (can_ch.valid && is_z) begin
          crc_init   = 1'b1;
          state_next = ST_CRC;
        end else if (can_ch.valid && is_tick && period_hit && send_pending) begin
          send_start = 1'b1;
          state_next = ST_SEND;
        end
      end
      ST_CRC: begin
        crc_step = 1'b1;
        if (idx == IDX_REC_LAST) begin
          state_next = ST_IDLE;
        end
      end
      ST_SEND: begin
        if (!out_valid || ser_ch.ready) begin
          out_load = 1'b1;
          if (idx == IDX_LAST) begin
            send_done  = 1'b1;
            state_next = ST_IDLE;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // byte index: record start for a commit, packet start for a send
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= IDX_FIRST;
    end else if (crc_init) begin
      idx <= IDX_REC_FIRST;
    end else if (send_start) begin
      idx <= IDX_FIRST;
    end else if (crc_step || out_load) begin
      idx <= idx + 1'b1;
    end
  end

  // record and scheduling state
  always_ff @(posedge clk) begin
    if (rst) begin
      rot_x_bytes  <= '0;
      rot_y_bytes  <= '0;
      rot_z_bytes  <= '0;
      seq_count    <= '0;
      send_pending <= 1'b0;
      tick_count   <= '0;
    end else begin
      if (in_acc && is_xy) begin
        // byte-reversed words: x from p7..p4, y from p3..p0
        rot_x_bytes <= {can_ch.can_payload[39:32], can_ch.can_payload[47:40],
                        can_ch.can_payload[55:48], can_ch.can_payload[63:56]};
        rot_y_bytes <= {can_ch.can_payload[7:0], can_ch.can_payload[15:8],
                        can_ch.can_payload[23:16], can_ch.can_payload[31:24]};
      end
      if (in_acc && is_z) begin
        rot_z_bytes  <= {can_ch.can_payload[7:0], can_ch.can_payload[15:8],
                         can_ch.can_payload[23:16], can_ch.can_payload[31:24]};
        send_pending <= 1'b1;
      end
      if (in_acc && is_tick) begin
        tick_count <= period_hit ? '0 : tick_sum[TICK_W-1:0];
      end
      if (send_start) begin
        send_pending <= 1'b0;
      end
      // sequence byte has already left by the time the last byte loads
      if (send_done) begin
        seq_count <= seq_next;
      end
    end
  end

  // output register, refilled in the cycle its transaction completes
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (ser_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte <= sel_byte;
      out_last <= (idx == IDX_LAST);
    end
  end

  assign can_ch.ready      = in_ready;
  assign ser_ch.valid      = out_valid;
  assign ser_ch.out_byte   = out_byte;
  assign ser_ch.frame_last = out_last;

endmodule

/* rtl/ifa_cfg_regs.sv */
// apb configuration registers of the imu frame assembler
// depends on ifa_pkg
module ifa_cfg_regs
  import ifa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_header <= RST_HEADER;
      cfg.temperature  <= RST_TEMP;
      cfg.status_byte  <= RST_STATUS;
      cfg.id_rate_xy   <= RST_ID_XY;
      cfg.id_rate_z    <= RST_ID_Z;
      cfg.send_period  <= RST_PERIOD;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_HEADER: cfg.frame_header <= pwdata;
        REG_TEMP:   cfg.temperature  <= pwdata[15:0];
        REG_STATUS: cfg.status_byte  <= pwdata[7:0];
        REG_ID_XY:  cfg.id_rate_xy   <= pwdata[ID_W-1:0];
        REG_ID_Z:   cfg.id_rate_z    <= pwdata[ID_W-1:0];
        REG_PERIOD: cfg.send_period  <= pwdata[TICK_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_HEADER: prdata = cfg.frame_header;
      REG_TEMP:   prdata = {16'd0, cfg.temperature};
      REG_STATUS: prdata = {24'd0, cfg.status_byte};
      REG_ID_XY:  prdata = {3'd0, cfg.id_rate_xy};
      REG_ID_Z:   prdata = {3'd0, cfg.id_rate_z};
      REG_PERIOD: prdata = {16'd0, cfg.send_period};
      default:    prdata = '0;
    endcase
  end

endmodule

/* rtl/ifa_crc_unit.sv */
// crc-32/mpeg-2 accumulator, one byte per step
// depends on ifa_pkg
module ifa_crc_unit
  import ifa_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              init,
  input  logic              step,
  input  logic [BYTE_W-1:0] data,
  output logic [31:0]       crc
);

  logic [31:0] crc_next;

  // eight polynomial divisions of the byte, msb first
  always_comb begin
    crc_next = crc ^ {data, 24'd0};
    for (int b = 0; b < 8; b++) begin
      if (crc_next[31]) begin
        crc_next = {crc_next[30:0], 1'b0} ^ CRC_POLY;
      end else begin
        crc_next = {crc_next[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc <= '0;
    end else if (init) begin
      crc <= CRC_INIT;
    end else if (step) begin
      crc <= crc_next;
    end
  end

endmodule

/* rtl/ifa_checker.sv */
// port-level checks of the imu frame assembler
// depends on ifa_pkg and binds to imu_frame_assembler_crc32
module ifa_checker
  import ifa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [BYTE_W-1:0] out_byte,
  input logic              out_last
);

  // stalled byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_byte) && $stable(out_last)))
    else $error("stalled output transaction changed");

  // reset empties the output register
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // inside a packet the input side stays closed
  a_send_busy: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_last) |-> !in_ready)
    else $error("input ready in the middle of a packet");

  // packet bytes leave without gaps
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !out_last) |=> out_valid)
    else $error("gap inside a packet");

endmodule

bind imu_frame_assembler_crc32 ifa_checker u_ifa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (can_ch.ready),
  .out_valid (ser_ch.valid),
  .out_ready (ser_ch.ready),
  .out_byte  (ser_ch.out_byte),
  .out_last  (ser_ch.frame_last)
);
